// File: hw/rtl/arm_swing_gait_sequencer_assert.svh
// Assertion macros for the arm swing gait sequencer.
// Uses the aclk / aresetn names of the including module.
`ifndef ARM_SWING_GAIT_SEQUENCER_ASSERT_SVH
`define ARM_SWING_GAIT_SEQUENCER_ASSERT_SVH

// Implication in the same cycle
`define ASGS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("asgs assertion failed");

// Implication checked in the next cycle
`define ASGS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("asgs assertion failed");

`endif

// File: hw/rtl/asgs_pkg.sv
// Package for the arm swing gait sequencer: types, codes and constants.
// No dependencies.
`default_nettype none
package asgs_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FRM_W  = 16;   // phase frame count width
    localparam int PROG_W = 16;   // quotient bits of progress

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_LEFT  = 2'd1;
    localparam logic [1:0] KIND_RIGHT = 2'd2;

    localparam logic [1:0] MODE_SUPPORT = 2'd0;
    localparam logic [1:0] MODE_SWING   = 2'd1;
    localparam logic [1:0] MODE_DOUBLE  = 2'd2;
    localparam logic [1:0] MODE_PDOUBLE = 2'd3;

    localparam logic CFG_IS_LEFT   = 1'b0;
    localparam logic CFG_AMPLITUDE = 1'b1;

    localparam logic [16:0] COEF_A     = 17'd51472;
    localparam logic [16:0] COEF_B     = 17'd21024;
    localparam logic [16:0] COEF_C     = 17'd2320;
    localparam logic [16:0] INV_TWO_PI = 17'd10430;
    localparam logic [16:0] ONE_Q16    = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_PHASE, ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3,
        ST_SIN4, ST_SIN5, ST_SIN6, ST_SIN7, ST_EASE, ST_MULD, ST_OFS
    } state_t;

    typedef struct packed {
        logic              done;
        logic [PROG_W-1:0] quot;
    } div_stat_t;

    function automatic logic [1:0] following_mode(input logic [1:0] m);
        logic [1:0] r;
        unique case (m)
            MODE_SUPPORT: r = MODE_DOUBLE;
            MODE_SWING:   r = MODE_PDOUBLE;
            MODE_DOUBLE:  r = MODE_SWING;
            default:      r = MODE_SUPPORT;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/asgs_div.sv
// Restoring divider: quot = num * 2^16 / den, one quotient bit a cycle.
// Depends on asgs_pkg; num < den is required.
`default_nettype none
module asgs_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [asgs_pkg::FRM_W-1:0]  num,
    input  wire logic [asgs_pkg::FRM_W-1:0]  den,
    output asgs_pkg::div_stat_t              stat
);
    import asgs_pkg::*;

    localparam int CW = $clog2(PROG_W + 1);

    logic [FRM_W:0]    rem_reg, rem_next;
    logic [FRM_W-1:0]  den_reg;
    logic [PROG_W-1:0] quot_reg, quot_next;
    logic [CW-1:0]     cnt_reg;
    logic              done_reg;
    logic [FRM_W:0]    r2;
    logic              ge;

    always_comb begin
        r2 = {rem_reg[FRM_W-1:0], 1'b0};
        ge = r2 >= {1'b0, den_reg};
        rem_next  = ge ? r2 - {1'b0, den_reg} : r2;
        quot_next = {quot_reg[PROG_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(PROG_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quot_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;
endmodule
`default_nettype wire

// File: hw/rtl/arm_swing_gait_sequencer.sv
// Arm swing gait sequencer, top level: sequencer, shared multiplier, datapath.
// Depends on asgs_pkg, asgs_div and arm_swing_gait_sequencer_assert.svh.
//
// A tick request holds the input while the progress divide in asgs_div runs (it is
// skipped when progress saturates) and the datapath steps run, plus any wait for the
// previous result to be taken; the 17x17
// multiplier is stepped through the sine polynomial, the easing term and the
// final scaling. Start requests and kind 3 are taken while idle and give no
// result. s_tready is high only while the sequencer is idle; the result
// register frees once m_tready takes it.
`default_nettype none
module arm_swing_gait_sequencer #(
    parameter int COUNT_WIDTH = asgs_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] single_support_frames, [31:16] double_support_frames
    input  wire logic [2:0]  s_tuser,   // [1:0] kind, [2] step_is_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] shoulder_pitch_offset
    output logic [1:0]       m_tuser,   // [1:0] mode_after
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [14:0] cfg_wdata
);
    import asgs_pkg::*;

    localparam int CMPW = (COUNT_WIDTH > FRM_W) ? COUNT_WIDTH : FRM_W;

    // configuration
    logic        is_left_reg;
    logic [14:0] amp_reg;

    // sequencer state
    state_t state_reg, state_next;
    logic [1:0]             mode_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   first_reg;
    logic                   prev_end_reg;

    // latched request
    logic [FRM_W-1:0] ss_reg, ds_reg;
    logic             end_reg;

    // datapath
    logic [16:0]        p_reg;
    logic [15:0]        x_reg, x2_reg, x3_reg, x5_reg;
    logic               sneg_reg;
    logic [33:0]        prod_reg, acc_reg;
    logic [16:0]        e_reg;
    logic signed [16:0] start_reg;
    logic [16:0]        mag_reg;
    logic               dneg_reg;

    // output register
    logic        m_tvalid_reg;
    logic [15:0] m_data_reg;
    logic [1:0]  m_user_reg;

    // decoded request
    logic [1:0]       in_kind;
    logic [FRM_W-1:0] in_ss, in_ds;
    logic             in_end;
    logic             accept, accept_tick;

    assign in_kind = s_tuser[1:0];
    assign in_end  = s_tuser[2];
    assign in_ss   = s_tdata[15:0];
    assign in_ds   = s_tdata[31:16];
    assign accept      = s_tvalid && s_tready;
    assign accept_tick = accept && (in_kind == KIND_TICK);

    // phase frame count and progress bypass
    logic [CMPW-1:0]    c_ext;
    logic [FRM_W-1:0]   f_sel;
    logic               bypass;
    logic signed [16:0] a_s, st_a, en_a;
    logic signed [17:0] diff;
    logic               div_start;
    div_stat_t          dstat;

    always_comb begin
        c_ext = CMPW'(count_reg);
        f_sel = in_end ? in_ds : in_ss;
        bypass = (!in_end && mode_reg[1]) || (f_sel == '0) ||
                 (c_ext >= CMPW'(f_sel));
        a_s = signed'({2'b00, amp_reg});
        // modes support and double swing back, the others forward
        if (mode_reg == MODE_SUPPORT || mode_reg == MODE_DOUBLE) begin
            st_a = a_s;
            en_a = -a_s;
        end else begin
            st_a = -a_s;
            en_a = a_s;
        end
        if (in_end) begin
            if (prev_end_reg) begin
                st_a = '0;
                en_a = '0;
            end else if (first_reg) begin
                st_a = '0;
                en_a = -en_a;
            end else begin
                st_a = -st_a;
                en_a = '0;
            end
        end
        diff = 18'(en_a) - 18'(st_a);
        div_start = accept_tick && !bypass;
    end

    asgs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (c_ext[FRM_W-1:0]),
        .den     (f_sel),
        .stat    (dstat)
    );

    // shared multiplier operand select
    logic [16:0] mul_a, mul_b;
    logic [33:0] acc_sub;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        acc_sub = acc_reg - prod_reg;
        case (state_reg)
            ST_SIN0: begin mul_a = {1'b0, x_reg}; mul_b = {1'b0, x_reg}; end
            ST_SIN1: begin mul_a = {1'b0, prod_reg[30:15]}; mul_b = {1'b0, x_reg}; end
            ST_SIN2: begin mul_a = {1'b0, prod_reg[30:15]}; mul_b = {1'b0, x2_reg}; end
            ST_SIN3: begin mul_a = COEF_A; mul_b = {1'b0, x_reg}; end
            ST_SIN4: begin mul_a = COEF_C; mul_b = {1'b0, x5_reg}; end
            ST_SIN5: begin mul_a = COEF_B; mul_b = {1'b0, x3_reg}; end
            ST_SIN7: begin mul_a = acc_reg[31:15]; mul_b = INV_TWO_PI; end
            ST_MULD: begin mul_a = mag_reg; mul_b = e_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // easing and final offset
    logic signed [18:0] e_s;
    logic [16:0]        e_clamp;
    logic [33:0]        d_sum;
    logic signed [18:0] res;
    logic [15:0]        res_sat;
    logic               out_free;
    always_comb begin
        e_s = sneg_reg ? 19'(p_reg) + 19'(prod_reg[29:15])
                       : 19'(p_reg) - 19'(prod_reg[29:15]);
        if (e_s < 0) begin
            e_clamp = '0;
        end else if (e_s > 19'(ONE_Q16)) begin
            e_clamp = ONE_Q16;
        end else begin
            e_clamp = e_s[16:0];
        end
        d_sum = prod_reg + 34'd32768;
        res = dneg_reg ? 19'(start_reg) - 19'(d_sum[32:16])
                       : 19'(start_reg) + 19'(d_sum[32:16]);
        if (res > 19'sd32767) begin
            res_sat = 16'h7FFF;
        end else if (res < -19'sd32768) begin
            res_sat = 16'h8000;
        end else begin
            res_sat = res[15:0];
        end
        out_free = !m_tvalid_reg || m_tready;
    end

    // mode advance after the frame is counted
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [1:0]             m1, m2;
    logic                   chg1, chg2;
    always_comb begin
        cnt_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        chg1 = CMPW'(cnt_inc) >= CMPW'(mode_reg[1] ? ds_reg : ss_reg);
        m1 = following_mode(mode_reg);
        chg2 = chg1 && ((m1[1] ? ds_reg : ss_reg) == '0);
        m2 = chg2 ? following_mode(m1) : (chg1 ? m1 : mode_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept_tick) begin
                          state_next = bypass ? ST_PHASE : ST_DIV;
                      end
            ST_DIV:   if (dstat.done) begin
                          state_next = ST_PHASE;
                      end
            ST_PHASE: state_next = ST_SIN0;
            ST_SIN0:  state_next = ST_SIN1;
            ST_SIN1:  state_next = ST_SIN2;
            ST_SIN2:  state_next = ST_SIN3;
            ST_SIN3:  state_next = ST_SIN4;
            ST_SIN4:  state_next = ST_SIN5;
            ST_SIN5:  state_next = ST_SIN6;
            ST_SIN6:  state_next = ST_SIN7;
            ST_SIN7:  state_next = ST_EASE;
            ST_EASE:  state_next = ST_MULD;
            ST_MULD:  state_next = ST_OFS;
            ST_OFS:   if (out_free) begin
                          state_next = ST_IDLE;
                      end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            is_left_reg  <= 1'b1;
            amp_reg      <= '0;
            mode_reg     <= MODE_SUPPORT;
            count_reg    <= '0;
            first_reg    <= 1'b1;
            prev_end_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_IS_LEFT:   is_left_reg <= cfg_wdata[0];
                    CFG_AMPLITUDE: amp_reg     <= cfg_wdata;
                    default:       ;
                endcase
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (accept && (in_kind == KIND_LEFT || in_kind == KIND_RIGHT)) begin
                mode_reg     <= (((in_kind == KIND_LEFT)) == is_left_reg) ?
                                MODE_DOUBLE : MODE_PDOUBLE;
                count_reg    <= '0;
                first_reg    <= 1'b1;
                prev_end_reg <= 1'b0;
            end
            if (state_reg == ST_OFS && out_free) begin
                m_tvalid_reg <= 1'b1;
                mode_reg     <= m2;
                count_reg    <= chg1 ? '0 : cnt_inc;
                if (chg1) begin
                    first_reg    <= 1'b0;
                    prev_end_reg <= end_reg;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        // product held while the offset waits for the result register
        if (state_reg != ST_OFS) begin
            prod_reg <= mul_a * mul_b;
        end
        if (accept_tick) begin
            ss_reg    <= in_ss;
            ds_reg    <= in_ds;
            end_reg   <= in_end;
            p_reg     <= ONE_Q16;
            start_reg <= st_a;
            dneg_reg  <= diff < 0;
            mag_reg   <= (diff < 0) ? 17'(-diff) : 17'(diff);
        end
        case (state_reg)
            ST_DIV:   if (dstat.done) begin
                          p_reg <= {1'b0, dstat.quot};
                      end
            ST_PHASE: begin
                // quarter-wave fold of the phase
                sneg_reg <= p_reg[15];
                x_reg    <= p_reg[14] ? 16'd32768 - {1'b0, p_reg[13:0], 1'b0}
                                      : {1'b0, p_reg[13:0], 1'b0};
            end
            ST_SIN1:  x2_reg <= prod_reg[30:15];
            ST_SIN2:  x3_reg <= prod_reg[30:15];
            ST_SIN3:  x5_reg <= prod_reg[30:15];
            ST_SIN4:  acc_reg <= prod_reg;
            ST_SIN5:  acc_reg <= acc_reg + prod_reg;
            ST_SIN6:  acc_reg <= acc_sub;
            ST_EASE:  e_reg <= e_clamp;
            ST_OFS:   if (out_free) begin
                          m_data_reg <= res_sat;
                          m_user_reg <= m2;
                      end
            default:  ;
        endcase
    end

    // result mode is captured together with the offset
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`include "arm_swing_gait_sequencer_assert.svh"

    `ASGS_ASSERT_IMPL(a_div_from_idle, div_start, state_reg == ST_IDLE)
    `ASGS_ASSERT_NEXT(a_tick_busy, accept_tick, state_reg != ST_IDLE)
    `ASGS_ASSERT_IMPL(a_result_from_ofs, $rose(m_tvalid_reg), $past(state_reg) == ST_OFS)
    `ASGS_ASSERT_IMPL(a_div_done_in_div, dstat.done, state_reg == ST_DIV)

endmodule
`default_nettype wire
